// ----- hw/rtl/sort_engine_ascending_descending_unit_defines.svh -----
// Assertion macros used by the checker file of the sort engine.
`ifndef SORT_ENGINE_ASCENDING_DESCENDING_UNIT_DEFINES_SVH
`define SORT_ENGINE_ASCENDING_DESCENDING_UNIT_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define SEADU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SEADU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/seadu_pkg.sv -----
// Package: shared constants, payload types and controller/datapath interface.
`default_nettype none
package seadu_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_list;
      logic               overflowed;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;   // latch key, point at the tail, fetch the tail entry
      logic shift_step;  // move fetched entry up one slot, fetch the next lower
      logic place_key;   // write key at the hole, grow the list
      logic emit_read;   // fetch the entry at the emit pointer
      logic emit_load;   // load the fetched entry into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic store_full;  // list already holds MAX_ELEMENTS entries
      logic list_empty;  // nothing stored yet
      logic hole_at_one; // insertion hole sits at slot 1
      logic goes_after;  // fetched entry belongs after the key
      logic key_last;    // latched item closes the list
      logic emit_final;  // emit pointer is at the last entry
      logic out_free;    // output register can take a beat next cycle
   } status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/seadu_datapath.sv -----
// Datapath: element store, insertion pointers, list counters and output register.
`default_nettype none
module seadu_datapath
   import seadu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_payload,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire cmd_type    cmd,
   output status_type      status,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_payload
);

   logic [31:0]       store_ff [MAX_ELEMENTS];
   logic [31:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       wr_data;

   logic              ascending_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [ADDR_W-1:0] hole_ff, hole_in;
   logic [ADDR_W-1:0] emit_ff, emit_in;
   logic signed [31:0] key_ff;
   logic              last_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff;
   logic              emit_final;

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_comb begin
      rd_addr = emit_ff;
      if (cmd.take_item) begin
         rd_addr = ADDR_W'(count_ff - CNT_W'(1));
      end else if (cmd.shift_step) begin
         rd_addr = hole_ff - ADDR_W'(2);
      end
   end

   always_comb begin
      wr_en   = cmd.shift_step | cmd.place_key;
      wr_addr = hole_ff;
      wr_data = cmd.shift_step ? rd_data_ff : key_ff;
   end

   assign emit_final = ((CNT_W'(emit_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      hole_in      = hole_ff;
      emit_in      = emit_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      if (cmd.take_item) begin
         hole_in = ADDR_W'(count_ff);
         if (count_ff == CNT_W'(MAX_ELEMENTS)) begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.shift_step) begin
         hole_in = hole_ff - ADDR_W'(1);
      end
      if (cmd.place_key) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         emit_in      = emit_ff + ADDR_W'(1);
         if (emit_final) begin
            count_in    = '0;
            overflow_in = 1'b0;
            emit_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            ascending_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      if (cmd.take_item) begin
         key_ff  <= req_payload.value;
         last_ff <= req_payload.is_last;
      end
      if (cmd.emit_load) begin
         out_ff.sorted_value <= rd_data_ff;
         out_ff.end_of_list  <= emit_final;
         out_ff.overflowed   <= overflow_ff;
      end
   end

   always_comb begin
      status.store_full  = (count_ff == CNT_W'(MAX_ELEMENTS));
      status.list_empty  = (count_ff == '0);
      status.hole_at_one = (hole_ff == ADDR_W'(1));
      status.goes_after  = ascending_ff ? ($signed(rd_data_ff) > key_ff)
                                        : ($signed(rd_data_ff) < key_ff);
      status.key_last    = last_ff;
      status.emit_final  = emit_final;
      status.out_free    = ~out_valid_ff | ~rsp_stall;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/seadu_controller.sv -----
// Controller: sequences loading, insertion and emitting of one list.
`default_nettype none
module seadu_controller
   import seadu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_is_last,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SHIFT   = 3'd1;
   localparam logic [2:0] ST_PLACE   = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT_LD = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (status.store_full) begin
                  // drop the beat; a dropped last beat still closes the list
                  state_in = req_is_last ? ST_EMIT_RD : ST_IDLE;
               end else if (status.list_empty) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (status.goes_after) begin
               cmd.shift_step = 1'b1;
               state_in = status.hole_at_one ? ST_PLACE : ST_SHIFT;
            end else begin
               cmd.place_key = 1'b1;
               state_in = status.key_last ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.place_key = 1'b1;
            state_in = status.key_last ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            if (status.out_free) begin
               cmd.emit_read = 1'b1;
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in = status.emit_final ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/sort_engine_ascending_descending_unit.sv -----
// Sort engine: collects a list of signed words and returns it in sorted order.
// Usage:
//  - req channel (req_valid/req_stall/req_payload) carries one list element
//    per beat; a beat with is_last set closes the list. Up to MAX_ELEMENTS
//    elements are kept; further beats are dropped and flagged as overflowed.
//  - csr_write_enable/csr_write_data set the order: 1 ascending, 0 descending.
//    Write it only between lists.
//  - rsp channel returns every stored element, sorted, end_of_list on the
//    final beat, overflowed the same on every beat of the list.
// Operation:
//  - each stored element is inserted into place as it arrives: the tail entry
//    is fetched, each stored entry it moves past goes up one slot (one memory
//    read and one write per cycle), then the key is written into the hole.
//  - a closed list then streams out one beat at a time (registered memory
//    read, then the output register); the first beat follows once the last
//    element is placed or a dropped closing beat is taken.
//  - the final beat may wait in the output register while the next list
//    already loads. A stalled rsp beat holds; emission pauses behind it.
// Reset clears the list, the overflow flag and the output, and selects
// ascending order. The element memory is not cleared.
`default_nettype none
module sort_engine_ascending_descending_unit
   import seadu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // Control: decide per cycle which datapath step runs.
   seadu_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_payload.is_last),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Data: memory, pointers, counters, direction register and output beat.
   seadu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/seadu_checker.sv -----
// Checker: port-level properties of the sort engine, bound to the top level.
`default_nettype none
`include "sort_engine_ascending_descending_unit_defines.svh"
module seadu_checker
   import seadu_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   logic req_last_beat;
   logic rsp_mid_beat;

   assign req_last_beat = req_valid & ~req_stall & req_payload.is_last;
   assign rsp_mid_beat  = rsp_valid & ~rsp_stall & ~rsp_payload.end_of_list;

   `SEADU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload), "stalled rsp beat changed")
   `SEADU_ASSERT_NEXT(a_busy_after_last, clock, reset, req_last_beat,
      req_stall, "input taken right after a closing beat")
   `SEADU_ASSERT_NEXT(a_busy_mid_list, clock, reset, rsp_mid_beat,
      req_stall, "input taken while a list is still emitting")

endmodule

bind sort_engine_ascending_descending_unit seadu_checker u_seadu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the sort engine: signed word lists against a sorting predictor.
module tb;
   import seadu_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = 80;   // longest insertion plus the emit pipeline
   localparam int RANDOM_ITEMS   = 300;
   localparam int HOLDOFF_CYCLES = 1500;

   localparam logic ORDER_ASCENDING  = 1'b1;
   localparam logic ORDER_DESCENDING = 1'b0;

   typedef enum logic {STEP_ITEM, STEP_SET_ORDER} step_kind_type;

   // One row of the directed table. A typed row is a one-element list, so its
   // beat is the value itself, end_of_list set and no overflow.
   typedef struct packed {
      step_kind_type kind;
      logic [31:0]   value;
      logic          is_last;
      logic          typed;
      logic [31:0]   exp_value;
   } script_row_type;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_payload      = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   sort_engine_ascending_descending_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Predictor state: the list being collected and the sorted beats still owed.
   logic signed [31:0] pending_list[$];
   bit                 pending_overflow = 1'b0;
   logic               order_ascending  = ORDER_ASCENDING;
   rsp_type            sorted_beats[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   bit holdoff_request = 1'b0;

   // Store one accepted element; on the closing element sort the list and
   // queue its beats (unless the caller types them in itself).
   function automatic void take_element(input req_type item, input bit emit);
      logic signed [31:0] ordered[$];
      logic signed [31:0] key;
      rsp_type            beat;
      int                 i;
      int                 j;
      if (pending_list.size() < MAX_ELEMENTS) begin
         pending_list.push_back(item.value);
      end else begin
         pending_overflow = 1'b1;
      end
      if (item.is_last) begin
         ordered = pending_list;
         for (i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j = i;
            while (j > 0 && (order_ascending ? ordered[j-1] > key : ordered[j-1] < key)) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = key;
         end
         if (emit) begin
            foreach (ordered[k]) begin
               beat.sorted_value = ordered[k];
               beat.end_of_list  = (k == ordered.size() - 1);
               beat.overflowed   = pending_overflow;
               sorted_beats.push_back(beat);
            end
         end
         pending_list.delete();
         pending_overflow = 1'b0;
      end
   endfunction

   // Offer one beat in bursts; drop valid for a random gap between bursts.
   // Called at a rising edge, returns at the edge that accepted the beat.
   task automatic offer(input req_type item, input bit emit);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      take_element(item, emit);
   endtask

   // Change the order only with the block drained and settled.
   task automatic set_order(input logic ascending);
      req_valid <= 1'b0;
      while (sorted_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ascending;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order_ascending = ascending;
   endtask

   initial begin : stimulus
      script_row_type script [20];
      req_type        item;
      int             list_len;
      int             lists_sent;
      int             items_sent;
      int             e;

      // one-element lists: both extremes, zero and minus one, straight after reset (ascending)
      script[0]  = '{STEP_ITEM, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff};
      script[1]  = '{STEP_ITEM, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000};
      script[2]  = '{STEP_ITEM, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000};
      script[3]  = '{STEP_ITEM, 32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff};
      // ascending list with both extremes, zero, minus one and a duplicate
      script[4]  = '{STEP_ITEM, 32'h0000_0005, 1'b0, 1'b0, 32'h0};
      script[5]  = '{STEP_ITEM, 32'hffff_fffd, 1'b0, 1'b0, 32'h0};
      script[6]  = '{STEP_ITEM, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0};
      script[7]  = '{STEP_ITEM, 32'h8000_0000, 1'b0, 1'b0, 32'h0};
      script[8]  = '{STEP_ITEM, 32'h0000_0000, 1'b0, 1'b0, 32'h0};
      script[9]  = '{STEP_ITEM, 32'hffff_ffff, 1'b0, 1'b0, 32'h0};
      script[10] = '{STEP_ITEM, 32'h0000_0005, 1'b1, 1'b0, 32'h0};
      // descending list, alternating bit patterns
      script[11] = '{STEP_SET_ORDER, 32'(ORDER_DESCENDING), 1'b0, 1'b0, 32'h0};
      script[12] = '{STEP_ITEM, 32'h0000_0001, 1'b0, 1'b0, 32'h0};
      script[13] = '{STEP_ITEM, 32'h8000_0000, 1'b0, 1'b0, 32'h0};
      script[14] = '{STEP_ITEM, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0};
      script[15] = '{STEP_ITEM, 32'h0000_0001, 1'b0, 1'b0, 32'h0};
      script[16] = '{STEP_ITEM, 32'haaaa_aaaa, 1'b0, 1'b0, 32'h0};
      script[17] = '{STEP_ITEM, 32'h5555_5555, 1'b1, 1'b0, 32'h0};
      script[18] = '{STEP_ITEM, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678};
      script[19] = '{STEP_SET_ORDER, 32'(ORDER_ASCENDING), 1'b0, 1'b0, 32'h0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[n]) begin
         if (script[n].kind == STEP_SET_ORDER) begin
            set_order(script[n].value[0]);
         end else begin
            item.value   = script[n].value;
            item.is_last = script[n].is_last;
            offer(item, !script[n].typed);
            if (script[n].typed) begin
               sorted_beats.push_back(rsp_type'{sorted_value: script[n].exp_value,
                                                end_of_list: 1'b1, overflowed: 1'b0});
            end
         end
      end

      // Random lists. The first overflows (its closing beat is dropped) and
      // runs under the receiver hold-off; the second fills the store exactly.
      holdoff_request = 1'b1;
      items_sent = 0;
      lists_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (lists_sent > 0 && $urandom_range(0, 3) == 0) begin
            set_order(($urandom_range(0, 1) != 0) ? ORDER_ASCENDING : ORDER_DESCENDING);
         end
         if (lists_sent == 0) begin
            list_len = MAX_ELEMENTS + 4;
         end else if (lists_sent == 1) begin
            list_len = MAX_ELEMENTS;
         end else begin
            case ($urandom_range(0, 9))
               0:       list_len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 8);
               1, 2:    list_len = $urandom_range(9, MAX_ELEMENTS);
               default: list_len = $urandom_range(1, 8);
            endcase
         end
         for (e = 1; e <= list_len; e++) begin
            case ($urandom_range(0, 3))
               0: item.value = $urandom_range(0, 6) - 3;   // near zero, many ties
               1: begin
                  case ($urandom_range(0, 3))
                     0:       item.value = 32'h8000_0000;
                     1:       item.value = 32'h7fff_ffff;
                     2:       item.value = 32'h0000_0000;
                     default: item.value = 32'hffff_ffff;
                  endcase
               end
               default: item.value = $urandom();
            endcase
            item.is_last = (e == list_len);
            offer(item, 1'b1);
            items_sent++;
         end
         lists_sent++;
      end

      req_valid <= 1'b0;
      while (sorted_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver stall: one long hold-off while the sender keeps going, then a
   // mode picked at each wrap of the stall phase (never, light or heavy stalling).
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;
   int stall_phase  = 0;
   int stall_mode   = 0;

   always @(posedge clock) begin
      stall_phase <= (stall_phase == 49) ? 0 : stall_phase + 1;
      if (stall_phase == 0) begin
         stall_mode <= $urandom_range(0, 2);
      end
      if (holdoff_request && !holdoff_done) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Compare each accepted result beat with the oldest one owed.
   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_beats.size() == 0) begin
            $display("%0t: beat with none owed: expected nothing, actual %h",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = sorted_beats.pop_front();
            if (rsp_payload.sorted_value !== want.sorted_value) begin
               $display("%0t: sorted_value expected %0d actual %0d",
                        $time, want.sorted_value, rsp_payload.sorted_value);
               mismatch_count++;
            end
            if (rsp_payload.end_of_list !== want.end_of_list) begin
               $display("%0t: end_of_list expected %b actual %b",
                        $time, want.end_of_list, rsp_payload.end_of_list);
               mismatch_count++;
            end
            if (rsp_payload.overflowed !== want.overflowed) begin
               $display("%0t: overflowed expected %b actual %b",
                        $time, want.overflowed, rsp_payload.overflowed);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
